// File: design/irmp_pkg.sv
// ----------------------------------------------------------------------------
// irmp_pkg
// Shared types, constants and the arctangent table of the impedance ratio
// block.
// ----------------------------------------------------------------------------
package irmp_pkg;

	localparam int SAMPLE_BITS_DEF  = 18;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int RCAL_W   = 24;
	localparam int MAG_W    = 40;
	localparam int PHASE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int WORD_W   = 32;
	localparam int ZW       = 24;
	localparam int CNT_W    = 6;

	localparam logic [RCAL_W-1:0] RCAL_RESET = 24'd1000;

	localparam logic signed [ZW-1:0] HALF_PI_Q20 = 24'sd1647099;
	localparam int PHASE_LIMIT = 25736;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

	localparam logic [CNT_W-1:0] SQ_LAST   = 6'd4;
	localparam logic [CNT_W-1:0] ROOT_LAST = 6'd31;
	localparam logic [CNT_W-1:0] DIV_LAST  = 6'd40;

	typedef struct packed {
		logic             load_word;
		logic [1:0]       word_sel;
		logic             sq_step;
		logic             norm_first;
		logic             norm_step;
		logic             root_init;
		logic             root_step;
		logic             cordic_step;
		logic             mul_step;
		logic             div_init;
		logic             div_step;
		logic             out_load;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic norm_done;
	} stat_t;

	// Arctangent of 2^-i in radians, Q.20.
	function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:    v = 24'sd823550;
			5'd1:    v = 24'sd486170;
			5'd2:    v = 24'sd256879;
			5'd3:    v = 24'sd130396;
			5'd4:    v = 24'sd65451;
			5'd5:    v = 24'sd32757;
			5'd6:    v = 24'sd16383;
			5'd7:    v = 24'sd8192;
			5'd8:    v = 24'sd4096;
			5'd9:    v = 24'sd2048;
			5'd10:   v = 24'sd1024;
			5'd11:   v = 24'sd512;
			5'd12:   v = 24'sd256;
			5'd13:   v = 24'sd128;
			5'd14:   v = 24'sd64;
			5'd15:   v = 24'sd32;
			5'd16:   v = 24'sd16;
			5'd17:   v = 24'sd8;
			5'd18:   v = 24'sd4;
			5'd19:   v = 24'sd2;
			5'd20:   v = 24'sd1;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: design/irmp_cordic.sv
// ----------------------------------------------------------------------------
// irmp_cordic
// Vectoring CORDIC giving atan2(-im, re) in Q.20 radians, one step a cycle.
// ----------------------------------------------------------------------------
module irmp_cordic #(
	parameter int SAMPLE_BITS = irmp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            init,
	input  logic                            step,
	input  logic [4:0]                      idx,
	input  logic signed [SAMPLE_BITS-1:0]   re,
	input  logic signed [SAMPLE_BITS-1:0]   im,
	output logic signed [irmp_pkg::ZW-1:0]  angle
);
	import irmp_pkg::*;

	localparam int XW = SAMPLE_BITS + 3;

	logic signed [XW-1:0] xe, ye, x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q;
	logic                 zero_q;

	assign xe = {{3{re[SAMPLE_BITS-1]}}, re};
	assign ye = -{{3{im[SAMPLE_BITS-1]}}, im};
	assign xs = x_q >>> idx;
	assign ys = y_q >>> idx;

	always_ff @(posedge clk) begin
		if (init) begin
			zero_q <= (re == '0) && (im == '0);
			if (xe < 0) begin
				if (ye >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= HALF_PI_Q20;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -HALF_PI_Q20;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (step) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q20(idx);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q20(idx);
			end
		end
	end

	assign angle = zero_q ? '0 : z_q;

endmodule

// File: design/irmp_dp.sv
// ----------------------------------------------------------------------------
// irmp_dp
// Datapath: sample store, squares, scaling, square roots, divider, CORDIC
// pair and the result registers.
// ----------------------------------------------------------------------------
module irmp_dp #(
	parameter int SAMPLE_BITS = irmp_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  irmp_pkg::cmd_t                      cmd,
	output irmp_pkg::stat_t                     stat,
	input  logic [irmp_pkg::WORD_W-1:0]         fifo_word,
	input  logic                                rcal_ohms_we,
	input  logic [irmp_pkg::RCAL_W-1:0]         rcal_ohms,
	output logic [irmp_pkg::MAG_W-1:0]          magnitude_q8,
	output logic signed [irmp_pkg::PHASE_W-1:0] phase_q12,
	output logic [irmp_pkg::STATUS_W-1:0]       status
);
	import irmp_pkg::*;

	localparam int SB = SAMPLE_BITS;

	logic signed [SB-1:0] ref_re_q, ref_im_q, unk_re_q, unk_im_q, sel;
	logic [SB-1:0]        mag_in;
	logic [2*SB-1:0]      sq_q;
	logic [63:0]          a_q, b_q, m, bit_q;
	logic [5:0]           sh_q;
	logic                 zero_b_q;
	logic [63:0]          va_q, ra_q, vb_q, rb_q, ta, tb;
	logic [RCAL_W-1:0]    rcal_q;
	logic [62:0]          num_q;
	logic [30:0]          um_q, rem_q;
	logic [39:0]          dvd_q;
	logic                 sat_q;
	logic [31:0]          t;
	logic                 ge;
	logic signed [ZW-1:0] z_ref, z_unk;
	logic signed [ZW:0]   d;
	logic signed [ZW+1:0] dr;
	logic signed [ZW-7:0] ds;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcal_q <= RCAL_RESET;
		end else if (rcal_ohms_we) begin
			rcal_q <= rcal_ohms;
		end
	end

	// Sample store.
	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			case (cmd.word_sel)
				2'd0:    ref_re_q <= fifo_word[SB-1:0];
				2'd1:    ref_im_q <= fifo_word[SB-1:0];
				2'd2:    unk_re_q <= fifo_word[SB-1:0];
				default: unk_im_q <= fifo_word[SB-1:0];
			endcase
		end
	end

	// One shared squarer; the accumulation uses its registered product in the next cycle.
	always_comb begin
		case (cmd.cnt[1:0])
			2'd0:    sel = ref_re_q;
			2'd1:    sel = ref_im_q;
			2'd2:    sel = unk_re_q;
			default: sel = unk_im_q;
		endcase
	end
	assign mag_in = sel[SB-1] ? (~sel + 1'b1) : sel;

	assign m = (a_q > b_q) ? a_q : b_q;
	assign stat.norm_done = (sh_q == 6'd62) || (m[63:60] != 4'd0);

	assign ta = ra_q + bit_q;
	assign tb = rb_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_step) begin
			sq_q <= mag_in * mag_in;
			case (cmd.cnt[2:0])
				3'd1:    a_q <= 64'(sq_q);
				3'd2:    a_q <= a_q + 64'(sq_q);
				3'd3:    b_q <= 64'(sq_q);
				3'd4:    b_q <= b_q + 64'(sq_q);
				default: ;
			endcase
		end else if (cmd.norm_first) begin
			zero_b_q <= (b_q == '0);
			sh_q     <= '0;
			if (m[63:62] != 2'd0) begin
				a_q <= a_q >> 2;
				b_q <= b_q >> 2;
			end
		end else if (cmd.norm_step) begin
			a_q  <= a_q << 2;
			b_q  <= b_q << 2;
			sh_q <= sh_q + 6'd2;
		end
	end

	// Two restoring square roots, one result bit a cycle each.
	always_ff @(posedge clk) begin
		if (cmd.root_init) begin
			bit_q <= 64'd1 << 62;
			va_q  <= a_q;
			vb_q  <= b_q;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (cmd.root_step) begin
			bit_q <= bit_q >> 2;
			if (va_q >= ta) begin
				va_q <= va_q - ta;
				ra_q <= (ra_q >> 1) + bit_q;
			end else begin
				ra_q <= ra_q >> 1;
			end
			if (vb_q >= tb) begin
				vb_q <= vb_q - tb;
				rb_q <= (rb_q >> 1) + bit_q;
			end else begin
				rb_q <= rb_q >> 1;
			end
		end
	end

	// Scale and divide, one quotient bit a cycle over the low 40 bits.
	assign t  = {rem_q, dvd_q[39]};
	assign ge = t >= {1'b0, um_q};

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			num_q <= {55'(rcal_q) * 55'(ra_q[30:0]), 8'd0};
			um_q  <= rb_q[30:0];
		end else if (cmd.div_init) begin
			sat_q <= (um_q == '0) || ({8'd0, num_q[62:40]} >= um_q);
			rem_q <= {8'd0, num_q[62:40]};
			dvd_q <= num_q[39:0];
		end else if (cmd.div_step) begin
			rem_q <= ge ? 31'(t - {1'b0, um_q}) : t[30:0];
			dvd_q <= {dvd_q[38:0], ge};
		end
	end

	irmp_cordic #(.SAMPLE_BITS(SB)) u_cordic_ref (
		.clk   (clk),
		.init  (cmd.root_init),
		.step  (cmd.cordic_step),
		.idx   (cmd.cnt[4:0]),
		.re    (ref_re_q),
		.im    (ref_im_q),
		.angle (z_ref)
	);

	irmp_cordic #(.SAMPLE_BITS(SB)) u_cordic_unk (
		.clk   (clk),
		.init  (cmd.root_init),
		.step  (cmd.cordic_step),
		.idx   (cmd.cnt[4:0]),
		.re    (unk_re_q),
		.im    (unk_im_q),
		.angle (z_unk)
	);

	assign d  = {z_ref[ZW-1], z_ref} - {z_unk[ZW-1], z_unk};
	assign dr = {d[ZW], d} + (ZW+2)'(128);
	assign ds = dr[ZW+1:8];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (zero_b_q) begin
				magnitude_q8 <= '1;
				status       <= STATUS_ZERO;
			end else if (sat_q) begin
				magnitude_q8 <= '1;
				status       <= STATUS_SAT;
			end else begin
				magnitude_q8 <= dvd_q;
				status       <= STATUS_OK;
			end
			if (ds > PHASE_LIMIT) begin
				phase_q12 <= PHASE_W'(PHASE_LIMIT);
			end else if (ds < -PHASE_LIMIT) begin
				phase_q12 <= PHASE_W'(-PHASE_LIMIT);
			end else begin
				phase_q12 <= ds[PHASE_W-1:0];
			end
		end
	end

endmodule

// File: design/irmp_ctrl.sv
// ----------------------------------------------------------------------------
// irmp_ctrl
// Sequencer: word grouping, the handshakes and the step commands.
// ----------------------------------------------------------------------------
module irmp_ctrl #(
	parameter int CORDIC_STEPS = irmp_pkg::CORDIC_STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            word_valid,
	output logic            word_stall,
	input  logic            burst_end,
	output logic            result_valid,
	input  logic            result_stall,
	output irmp_pkg::cmd_t  cmd,
	input  irmp_pkg::stat_t stat
);
	import irmp_pkg::*;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_SQ      = 3'd1;
	localparam logic [2:0] ST_NORM    = 3'd2;
	localparam logic [2:0] ST_ROOT    = 3'd3;
	localparam logic [2:0] ST_MUL     = 3'd4;
	localparam logic [2:0] ST_DIV     = 3'd5;
	localparam logic [2:0] ST_FIN     = 3'd6;

	logic [2:0]       state_q, state_d;
	logic [1:0]       pos_q, pos_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             valid_q, accept, slot_free;

	assign word_stall   = state_q != ST_COLLECT;
	assign accept       = word_valid && !word_stall;
	assign result_valid = valid_q;
	assign slot_free    = !valid_q || !result_stall;

	always_comb begin
		cmd          = '0;
		cmd.cnt      = cnt_q;
		cmd.word_sel = pos_q;
		state_d      = state_q;
		pos_d        = pos_q;
		cnt_d        = cnt_q;
		case (state_q)
			ST_COLLECT: begin
				if (accept) begin
					cmd.load_word = 1'b1;
					cnt_d         = '0;
					if (pos_q == 2'd3) begin
						pos_d   = 2'd0;
						state_d = ST_SQ;
					end else begin
						pos_d = burst_end ? 2'd0 : pos_q + 2'd1;
					end
				end
			end
			ST_SQ: begin
				cmd.sq_step = 1'b1;
				if (cnt_q == SQ_LAST) begin
					cnt_d   = '0;
					state_d = ST_NORM;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_NORM: begin
				if (cnt_q == '0) begin
					cmd.norm_first = 1'b1;
					cnt_d          = 6'd1;
				end else if (!stat.norm_done) begin
					cmd.norm_step = 1'b1;
				end else begin
					cmd.root_init = 1'b1;
					cnt_d         = '0;
					state_d       = ST_ROOT;
				end
			end
			ST_ROOT: begin
				cmd.root_step   = 1'b1;
				cmd.cordic_step = cnt_q < CNT_W'(CORDIC_STEPS);
				if (cnt_q == ROOT_LAST) begin
					state_d = ST_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					cmd.div_init = 1'b1;
				end else begin
					cmd.div_step = 1'b1;
				end
				if (cnt_q == DIV_LAST) begin
					state_d = ST_FIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_COLLECT;
				end
			end
			default: begin
				state_d = ST_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			pos_q   <= '0;
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!valid_q || !result_stall))
		else $error("result overwritten while still pending");
	a_group_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_q == 2'd3) |=> (state_q == ST_SQ))
		else $error("fourth word did not start the computation");
	a_burst_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && burst_end && pos_q != 2'd3) |=> (pos_q == 2'd0))
		else $error("burst end did not discard the partial group");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIV_LAST)
		else $error("step counter out of range");
`endif

endmodule

// File: design/impedance_ratio_magnitude_phase.sv
// ----------------------------------------------------------------------------
// impedance_ratio_magnitude_phase
// Ratiometric impedance magnitude and phase from groups of four DFT words.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+--------------------------------
//  word in   | word_valid / word_stall    | fifo_word, burst_end
//  result    | result_valid / result_stall| magnitude_q8, phase_q12, status
//  config    | rcal_ohms_we               | rcal_ohms
//
//  Words 0 to 2 of a group are taken one a cycle. The fourth word starts the
//  computation, during which word_stall is high: squares, scaling, square
//  root (with both CORDIC angles running alongside), the multiply, the
//  divider and the loading of the result, which waits for a free output
//  register. The square roots and the divider give one bit a cycle.
//  A waiting result is held in the output register, and new words are taken
//  meanwhile; a new result waits only if the previous one is still stalled.
//  Reset clears the sequencer, the output valid and rcal_ohms to 1000 ohms.
//
module impedance_ratio_magnitude_phase #(
	parameter int SAMPLE_BITS  = irmp_pkg::SAMPLE_BITS_DEF,
	parameter int CORDIC_STEPS = irmp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                word_valid,
	output logic                                word_stall,
	input  logic [irmp_pkg::WORD_W-1:0]         fifo_word,
	input  logic                                burst_end,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [irmp_pkg::MAG_W-1:0]          magnitude_q8,
	output logic signed [irmp_pkg::PHASE_W-1:0] phase_q12,
	output logic [irmp_pkg::STATUS_W-1:0]       status,
	input  logic                                rcal_ohms_we,
	input  logic [irmp_pkg::RCAL_W-1:0]         rcal_ohms
);
	import irmp_pkg::*;

	// Step commands from the sequencer and the scaling status back.
	cmd_t  cmd;
	stat_t stat;

	irmp_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.burst_end    (burst_end),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	// The datapath holds the samples, arithmetic units and result payload.
	irmp_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.fifo_word    (fifo_word),
		.rcal_ohms_we (rcal_ohms_we),
		.rcal_ohms    (rcal_ohms),
		.magnitude_q8 (magnitude_q8),
		.phase_q12    (phase_q12),
		.status       (status)
	);

endmodule

// File: tb/impedance_ratio_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// impedance_ratio_checker
// Watches the word and result channels of the impedance ratio block. It
// predicts each result from the accepted words and compares it with what the
// block delivers.
// ----------------------------------------------------------------------------
module impedance_ratio_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                word_valid,
	input  logic                                word_stall,
	input  logic [irmp_pkg::WORD_W-1:0]         fifo_word,
	input  logic                                burst_end,
	input  logic                                result_valid,
	input  logic                                result_stall,
	input  logic [irmp_pkg::MAG_W-1:0]          magnitude_q8,
	input  logic signed [irmp_pkg::PHASE_W-1:0] phase_q12,
	input  logic [irmp_pkg::STATUS_W-1:0]       status,
	input  logic                                rcal_ohms_we,
	input  logic [irmp_pkg::RCAL_W-1:0]         rcal_ohms,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  result_count
);
	import irmp_pkg::*;

	typedef struct packed {
		logic [MAG_W-1:0]           mag;
		logic signed [PHASE_W-1:0]  phase;
		logic [STATUS_W-1:0]        stat;
	} impedance_t;

	impedance_t expected_results[$];
	logic [RCAL_W-1:0] rcal_copy;
	logic [1:0] group_pos;
	longint grp_ref_re, grp_ref_im, grp_unk_re;

	function automatic longint word_sample(logic [WORD_W-1:0] w);
		return longint'($signed(w[17:0]));
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Vectoring CORDIC, atan2(y, x) in Q.20 radians.
	function automatic longint vector_angle(longint x, longint y);
		longint z, t, xs, ys;
		if (x == 0 && y == 0) return 0;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 1647099;
			end else begin
				t = x; x = -y; y = t; z = -1647099;
			end
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + longint'(atan_q20(i[4:0]));
			end else begin
				x = x - ys; y = y + xs; z = z - longint'(atan_q20(i[4:0]));
			end
		end
		return z;
	endfunction

	function automatic impedance_t predict_impedance(longint rr, longint ri, longint ur,
			longint ui, logic [RCAL_W-1:0] rc);
		impedance_t r;
		logic [63:0] a, b, m, rm, um;
		logic [127:0] num, q;
		int sh;
		longint d;
		r.stat = STATUS_OK;
		a = rr * rr + ri * ri;
		b = ur * ur + ui * ui;
		if (b == 0) begin
			r.mag = '1;
			r.stat = STATUS_ZERO;
		end else begin
			m = a > b ? a : b;
			if (m >= (64'd1 << 62)) begin
				a = a >> 2; b = b >> 2; m = m >> 2;
			end
			sh = 0;
			if (m != 0)
				while (sh < 62 && (m >> (60 - sh)) == 0) sh += 2;
			rm = int_sqrt(a << sh);
			um = int_sqrt(b << sh);
			if (um == 0) begin
				r.mag = '1;
				r.stat = STATUS_SAT;
			end else begin
				num = 128'(rc) * 256 * 128'(rm);
				q = num / um;
				if (q > 128'hFF_FFFF_FFFF) begin
					r.mag = '1;
					r.stat = STATUS_SAT;
				end else begin
					r.mag = q[MAG_W-1:0];
				end
			end
		end
		d = vector_angle(rr, -ri) - vector_angle(ur, -ui);
		d = (d + 128) >>> 8;
		if (d > PHASE_LIMIT) d = PHASE_LIMIT;
		if (d < -PHASE_LIMIT) d = -PHASE_LIMIT;
		r.phase = d[PHASE_W-1:0];
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		impedance_t e;
		longint s;
		if (!arst_n) begin
			rcal_copy <= RCAL_RESET;
			group_pos <= 0;
			fail_count <= 0;
			result_count <= 0;
			expected_results.delete();
		end else begin
			if (rcal_ohms_we) rcal_copy <= rcal_ohms;
			if (word_valid && !word_stall) begin
				s = word_sample(fifo_word);
				case (group_pos)
					2'd0: grp_ref_re <= s;
					2'd1: grp_ref_im <= s;
					2'd2: grp_unk_re <= s;
					default: expected_results.push_back(predict_impedance(
						grp_ref_re, grp_ref_im, grp_unk_re, s, rcal_copy));
				endcase
				group_pos <= (group_pos == 2'd3 || burst_end) ? 2'd0 : group_pos + 2'd1;
			end
			if (result_valid && !result_stall) begin
				result_count <= result_count + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: magnitude_q8 %0d", magnitude_q8);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_results.pop_front();
					if (magnitude_q8 !== e.mag || phase_q12 !== e.phase ||
							status !== e.stat) begin
						fail_count <= fail_count + 1;
						if (magnitude_q8 !== e.mag)
							$error("magnitude_q8 expected %0d actual %0d", e.mag, magnitude_q8);
						if (phase_q12 !== e.phase)
							$error("phase_q12 expected %0d actual %0d", e.phase, phase_q12);
						if (status !== e.stat)
							$error("status expected %0d actual %0d", e.stat, status);
					end
				end
			end
		end
	end

endmodule

// File: tb/impedance_ratio_magnitude_phase_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// impedance_ratio_magnitude_phase_test
// Drives groups of DFT words into the impedance ratio block under random
// gaps and stalls, with several calibration resistor values, and leaves the
// checking to the checker beside it.
// ----------------------------------------------------------------------------
module impedance_ratio_magnitude_phase_test;
	import irmp_pkg::*;

	logic clk, arst_n;
	logic word_valid, word_stall, burst_end;
	logic [WORD_W-1:0] fifo_word;
	logic result_valid, result_stall;
	logic [MAG_W-1:0] magnitude_q8;
	logic signed [PHASE_W-1:0] phase_q12;
	logic [STATUS_W-1:0] status;
	logic rcal_ohms_we;
	logic [RCAL_W-1:0] rcal_ohms;
	int fail_count, pending, result_count;
	int item_count;
	// The receiver holds off for a long stretch while this is set.
	logic long_hold;

	impedance_ratio_magnitude_phase i_dut (
		.clk(clk), .arst_n(arst_n),
		.word_valid(word_valid), .word_stall(word_stall),
		.fifo_word(fifo_word), .burst_end(burst_end),
		.result_valid(result_valid), .result_stall(result_stall),
		.magnitude_q8(magnitude_q8), .phase_q12(phase_q12), .status(status),
		.rcal_ohms_we(rcal_ohms_we), .rcal_ohms(rcal_ohms)
	);

	impedance_ratio_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Offers one word and waits at rising edges until it has been taken.
	// A random gap of idle cycles comes before it. Valid stays high on return
	// so that words can follow back to back; the caller drops it when it
	// stops sending.
	task automatic send_word(logic [WORD_W-1:0] w, logic last);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			word_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		word_valid <= 1;
		fifo_word <= w;
		burst_end <= last;
		@(posedge clk);
		while (word_stall) @(posedge clk);
		item_count++;
		@(negedge clk);
	endtask

	// Random word with the sample in the low 18 bits and junk above.
	function automatic logic [WORD_W-1:0] raw_word(logic [17:0] sample);
		logic [WORD_W-1:0] w;
		w = $urandom;
		w[17:0] = sample;
		return w;
	endfunction

	// A sample whose size is drawn on a log scale, so that small and large
	// magnitudes both turn up.
	function automatic logic [17:0] any_sample();
		logic [17:0] v;
		int k;
		k = $urandom_range(0, 4);
		if (k == 0) return 18'd0;
		v = 18'($urandom);
		if (k == 1) return v;
		return 18'($signed(v[7:0]) >>> $urandom_range(0, 7));
	endfunction

	task automatic send_group(logic [17:0] a, logic [17:0] b, logic [17:0] c,
			logic [17:0] d);
		send_word(raw_word(a), 0);
		send_word(raw_word(b), 0);
		send_word(raw_word(c), 0);
		send_word(raw_word(d), 1'($urandom_range(0, 1)));
	endtask

	// Waits until every expected result is back, then lets the block settle
	// before the register is rewritten.
	task automatic drain_and_write(logic [RCAL_W-1:0] value);
		word_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (150) @(negedge clk);
		rcal_ohms_we <= 1;
		rcal_ohms <= value;
		@(negedge clk);
		rcal_ohms_we <= 0;
	endtask

	// Receiver: each result waits a random number of cycles, sometimes none.
	initial begin
		int wait_cycles;
		result_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				result_stall <= 1;
			end else begin
				wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
				if (wait_cycles != 0) begin
					result_stall <= 1;
					repeat (wait_cycles) @(negedge clk);
				end
				result_stall <= 0;
				@(posedge clk);
				while (!result_valid) @(posedge clk);
			end
		end
	end

	initial begin
		#20_000_000;
		$display("impedance_ratio_magnitude_phase_test NOT OK");
		$finish;
	end

	initial begin
		logic [RCAL_W-1:0] settings[4];
		int hold_cycles;
		settings = '{24'd1, 24'd10_000_000, 24'hFFFFFF, 24'd0};
		long_hold = 0;
		item_count = 0;
		arst_n = 0;
		word_valid = 0;
		fifo_word = 0;
		burst_end = 0;
		rcal_ohms_we = 0;
		rcal_ohms = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;

		// Directed part at the reset value of 1000 ohms: field extremes, an
		// unknown of zero, zero vectors, saturation and broken groups.
		send_group(18'h1FFFF, 18'h20000, 18'h1FFFF, 18'h20000);
		send_group(18'h20000, 18'h1FFFF, 18'h0, 18'h0);
		send_group(18'h0, 18'h0, 18'h1, 18'h0);
		send_group(18'h1FFFF, 18'h1FFFF, 18'h0, 18'h1);
		send_group(18'h20000, 18'h0, 18'h3FFFF, 18'h0);
		send_word(32'hFFFF_FFFF, 1);
		send_word(32'h0, 0);
		send_word(32'hFFFF_FFFF, 1);
		send_group(18'h0, 18'h1, 18'h20000, 18'h3FFFF);

		// Random part over several resistor values.
		for (int phase_no = 0; phase_no < 5; phase_no++) begin
			drain_and_write(phase_no < 4 ? settings[phase_no] : RCAL_W'($urandom));
			for (int g = 0; g < 18; g++) begin
				if ($urandom_range(0, 9) == 0)
					send_word($urandom, 1'($urandom_range(0, 1)));
				else
					send_group(any_sample(), any_sample(), any_sample(), any_sample());
			end
			if (phase_no == 1) begin
				// Hold results back so the block fills up and stalls its input.
				long_hold = 1;
				fork
					begin
						hold_cycles = 0;
						while (hold_cycles < 400) begin
							@(negedge clk);
							hold_cycles++;
						end
						long_hold = 0;
					end
					begin
						for (int g = 0; g < 4; g++)
							send_group(any_sample(), any_sample(), any_sample(),
								any_sample());
						word_valid <= 0;
					end
				join
			end
		end

		word_valid <= 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d words and checked %0d results over five resistor settings.",
			item_count, result_count);
		if (fail_count == 0)
			$display("impedance_ratio_magnitude_phase_test OK");
		else
			$display("impedance_ratio_magnitude_phase_test NOT OK");
		$finish;
	end

endmodule

// File: files.f
design/irmp_pkg.sv
design/irmp_cordic.sv
design/irmp_dp.sv
design/irmp_ctrl.sv
design/impedance_ratio_magnitude_phase.sv
tb/impedance_ratio_checker.sv
tb/impedance_ratio_magnitude_phase_test.sv
